// File: design/segint_pkg.sv
// shared constants of the segment intersection test
`default_nettype none

package segint_pkg;

  // coordinate field width on the stream and default significant width
  localparam int unsigned FIELD_WIDTH      = 32;
  localparam int unsigned COORD_WIDTH_DEF  = 32;
  localparam int unsigned NUM_COORDS       = 8;
  localparam int unsigned IN_TDATA_WIDTH   = FIELD_WIDTH * NUM_COORDS;
  localparam int unsigned OUT_TDATA_WIDTH  = 8;

  // tolerance register
  localparam int unsigned TOL_WIDTH        = 32;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd4;

  // field positions inside in_tdata
  localparam int unsigned F_AX = 0;
  localparam int unsigned F_AY = 1;
  localparam int unsigned F_BX = 2;
  localparam int unsigned F_BY = 3;
  localparam int unsigned F_CX = 4;
  localparam int unsigned F_CY = 5;
  localparam int unsigned F_DX = 6;
  localparam int unsigned F_DY = 7;

  // bit of the result inside out_tdata
  localparam int unsigned OUT_HIT_BIT = 0;

endpackage

`default_nettype wire

// File: design/segment_intersection_test.sv
// pipelined test of whether two 2-d segments cross or touch
//
// usage
//   in_*  : one segment pair per transfer, eight signed q16.16 coordinates in
//           in_tdata, first segment start/end then second segment start/end.
//           only the low COORD_WIDTH bits of each field are significant,
//           sign-extended from bit COORD_WIDTH-1.
//   out_* : one result per pair, bit 0 of out_tdata set when they intersect.
//   cfg_* : collinear tolerance on the cross products (units of 2^-32),
//           written while no pair is in flight; reset value 4.
// timing
//   four register stages: differences and bounding boxes, the eight
//   products, the four orientation sums, then the side classification and
//   final decision in the output register. one pair per cycle is taken
//   sustained while out_tready stays high. the depth is set by the
//   33 x 33 bit multiplies in their own stage.
// reset and stalls
//   rst_n low empties the pipeline and reloads the tolerance. while the
//   receiver holds out_tready low, stages fill behind the output register
//   and in_tready drops only once every stage is full; nothing is dropped.
`default_nettype none

module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // tdata, low bit up: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y (32 bits each)
  input  wire logic [segint_pkg::IN_TDATA_WIDTH-1:0]   in_tdata,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  // tdata, low bit up: intersects, then seven zero bits
  output logic [segint_pkg::OUT_TDATA_WIDTH-1:0]       out_tdata,
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  input  wire logic                                    cfg_we,
  input  wire logic [segint_pkg::TOL_WIDTH-1:0]        cfg_wdata
);
  import segint_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DFW  = W + 1;         // coordinate difference
  localparam int unsigned PW   = 2 * DFW;       // one product
  localparam int unsigned OW   = PW + 1;        // orientation sum
  localparam int unsigned CMPW = (OW > TOL_WIDTH + 2) ? OW : TOL_WIDTH + 2;

  // ---------------------------------------------------------------- tolerance
  logic [TOL_WIDTH-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // ------------------------------------------------------------ flow control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // a stage takes new data when it is empty or its content moves on
  assign rdy4      = !out_valid_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_tvalid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // ------------------------------------------- stage 1: differences and boxes
  logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = $signed(in_tdata[F_AX*FIELD_WIDTH +: W]);
  assign ay = $signed(in_tdata[F_AY*FIELD_WIDTH +: W]);
  assign bx = $signed(in_tdata[F_BX*FIELD_WIDTH +: W]);
  assign by = $signed(in_tdata[F_BY*FIELD_WIDTH +: W]);
  assign cx = $signed(in_tdata[F_CX*FIELD_WIDTH +: W]);
  assign cy = $signed(in_tdata[F_CY*FIELD_WIDTH +: W]);
  assign dx = $signed(in_tdata[F_DX*FIELD_WIDTH +: W]);
  assign dy = $signed(in_tdata[F_DY*FIELD_WIDTH +: W]);

  function automatic logic signed [DFW-1:0] sub_c(logic signed [W-1:0] p,
                                                  logic signed [W-1:0] q);
    logic signed [DFW-1:0] pe, qe;
    pe = {p[W-1], p};
    qe = {q[W-1], q};
    return pe - qe;
  endfunction

  // point within the closed range spanned by two ends, on both axes
  function automatic logic box_c(logic signed [W-1:0] ex, logic signed [W-1:0] ey,
                                 logic signed [W-1:0] fx, logic signed [W-1:0] fy,
                                 logic signed [W-1:0] px, logic signed [W-1:0] py);
    logic in_x, in_y;
    in_x = (px >= ex && px <= fx) || (px >= fx && px <= ex);
    in_y = (py >= ey && py <= fy) || (py >= fy && py <= ey);
    return in_x && in_y;
  endfunction

  // second segment direction and first segment endpoints relative to its start
  logic signed [DFW-1:0] dcx_r, dcy_r, acx_r, acy_r, bcx_r, bcy_r;
  // first segment direction and second segment endpoints relative to its start
  logic signed [DFW-1:0] bax_r, bay_r, cax_r, cay_r, dax_r, day_r;
  logic [3:0] box1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dcx_r  <= sub_c(dx, cx);
      dcy_r  <= sub_c(dy, cy);
      acx_r  <= sub_c(ax, cx);
      acy_r  <= sub_c(ay, cy);
      bcx_r  <= sub_c(bx, cx);
      bcy_r  <= sub_c(by, cy);
      bax_r  <= sub_c(bx, ax);
      bay_r  <= sub_c(by, ay);
      cax_r  <= sub_c(cx, ax);
      cay_r  <= sub_c(cy, ay);
      dax_r  <= sub_c(dx, ax);
      day_r  <= sub_c(dy, ay);
      box1_r <= {box_c(ax, ay, bx, by, dx, dy),
                 box_c(ax, ay, bx, by, cx, cy),
                 box_c(cx, cy, dx, dy, bx, by),
                 box_c(cx, cy, dx, dy, ax, ay)};
    end
  end

  // ------------------------------------------------------ stage 2: products
  logic signed [PW-1:0] p1_r, q1_r, p2_r, q2_r, p3_r, q3_r, p4_r, q4_r;
  logic [3:0] box2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p1_r   <= dcx_r * acy_r;
      q1_r   <= dcy_r * acx_r;
      p2_r   <= dcx_r * bcy_r;
      q2_r   <= dcy_r * bcx_r;
      p3_r   <= bax_r * cay_r;
      q3_r   <= bay_r * cax_r;
      p4_r   <= bax_r * day_r;
      q4_r   <= bay_r * dax_r;
      box2_r <= box1_r;
    end
  end

  // ------------------------------------------------ stage 3: orientations
  function automatic logic signed [OW-1:0] orient_c(logic signed [PW-1:0] p,
                                                    logic signed [PW-1:0] q);
    logic signed [OW-1:0] pe, qe;
    pe = {p[PW-1], p};
    qe = {q[PW-1], q};
    return pe - qe;
  endfunction

  logic signed [OW-1:0] d1_r, d2_r, d3_r, d4_r;
  logic [3:0] box3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      d1_r   <= orient_c(p1_r, q1_r);
      d2_r   <= orient_c(p2_r, q2_r);
      d3_r   <= orient_c(p3_r, q3_r);
      d4_r   <= orient_c(p4_r, q4_r);
      box3_r <= box2_r;
    end
  end

  // ------------------------------------------------ stage 4: sides and hit
  logic signed [CMPW-1:0] tol_pos, tol_neg;
  logic [3:0] above, below, flat;
  logic       straddle, touch, hit_nxt;
  logic       hit_r;

  assign tol_pos = $signed({{(CMPW-TOL_WIDTH){1'b0}}, tol_r});
  assign tol_neg = -tol_pos;

  // sign extension to the compare width
  function automatic logic signed [CMPW-1:0] ext_c(logic signed [OW-1:0] d);
    return CMPW'(d);
  endfunction

  always_comb begin
    above[0] = ext_c(d1_r) > tol_pos;
    above[1] = ext_c(d2_r) > tol_pos;
    above[2] = ext_c(d3_r) > tol_pos;
    above[3] = ext_c(d4_r) > tol_pos;
    below[0] = ext_c(d1_r) < tol_neg;
    below[1] = ext_c(d2_r) < tol_neg;
    below[2] = ext_c(d3_r) < tol_neg;
    below[3] = ext_c(d4_r) < tol_neg;
    // a product equal to the tolerance counts as collinear
    flat     = ~(above | below);
    straddle = ((above[0] && below[1]) || (below[0] && above[1])) &&
               ((above[2] && below[3]) || (below[2] && above[3]));
    touch    = |(flat & box3_r);
    hit_nxt  = straddle || touch;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      hit_r <= hit_nxt;
    end
  end

  always_comb begin
    out_tdata              = '0;
    out_tdata[OUT_HIT_BIT] = hit_r;
  end
  assign out_tvalid = out_valid_r;

  // ---------------------------------------------------------------- checks
  // nothing comes out in the cycle after reset
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a ready receiver keeps the whole pipeline moving
  a_ready_flow : assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled although the output is taken");

  // input back-pressure only when the output register is held
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  // a transfer reaches the output register when out_tready stays high in between
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

`default_nettype wire

// File: test/tb_segment_intersection_test.sv
// self-checking testbench for the segment intersection test
`timescale 1ns / 1ps

module tb_segment_intersection_test;
  import segint_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  // long enough to fill every pipeline stage and push back on the input
  localparam int LONG_HOLD    = 64;
  // four register stages, plus margin for anything stray
  localparam int DRAIN_CYCLES = 16;

  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_MAX = 32'h7fff_ffff;

  typedef logic [FIELD_WIDTH-1:0] coord_t;
  // declared high field first so that ax lands in the lowest bits, as on in_tdata
  typedef struct packed {
    coord_t dy, dx, cy, cx, by, bx, ay, ax;
  } seg_pair_t;

  // how a directed row gets its expected verdict
  typedef enum logic [1:0] { WANT_MISS, WANT_HIT, WANT_MODEL } verdict_t;

  typedef struct {
    seg_pair_t pair;
    verdict_t  want;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n      = 1'b0;
  logic [IN_TDATA_WIDTH-1:0]   in_tdata   = '0;
  logic                        in_tvalid  = 1'b0;
  wire                         in_tready;
  wire  [OUT_TDATA_WIDTH-1:0]  out_tdata;
  wire                         out_tvalid;
  logic                        out_tready = 1'b0;
  logic                        cfg_we     = 1'b0;
  logic [TOL_WIDTH-1:0]        cfg_wdata  = '0;

  // tolerance as the block should currently hold it
  logic [TOL_WIDTH-1:0] tolerance_now = TOL_RESET;
  // verdicts of accepted pairs, oldest first
  logic expected_hits[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  // long receiver hold-off: the sender asks, the receiver counts it out
  int hold_asks      = 0;
  int hold_seen      = 0;
  int ready_wait     = 0;
  // the sender never idles and the receiver adds no random stalls while this is set
  bit steady         = 1'b0;

  segment_intersection_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // orientation of c against the line a->b, exact: 33 bit differences,
  // 66 bit products, held in 72 bits so nothing can wrap
  function automatic logic signed [71:0] cross_term(input longint ax, ay, bx, by, cx, cy);
    logic signed [71:0] ux, uy, vx, vy;
    ux = bx - ax;
    uy = by - ay;
    vx = cx - ax;
    vy = cy - ay;
    return ux * vy - uy * vx;
  endfunction

  // strictly beyond the tolerance band on either side, else collinear;
  // a product equal to the tolerance counts as collinear
  function automatic int side_of_line(input logic signed [71:0] d,
                                      input logic [TOL_WIDTH-1:0] tol);
    logic signed [71:0] band;
    band = {40'd0, tol};
    if (d > band) return 1;
    if (d < -band) return -1;
    return 0;
  endfunction

  // c inside the box spanned by a and b, edges included
  function automatic bit in_box(input longint ax, ay, bx, by, cx, cy);
    longint xlo, xhi, ylo, yhi;
    xlo = (ax < bx) ? ax : bx;
    xhi = (ax < bx) ? bx : ax;
    ylo = (ay < by) ? ay : by;
    yhi = (ay < by) ? by : ay;
    return cx >= xlo && cx <= xhi && cy >= ylo && cy <= yhi;
  endfunction

  function automatic logic segments_meet(input seg_pair_t p, input logic [TOL_WIDTH-1:0] tol);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    int s1, s2, s3, s4;
    ax = $signed(p.ax);
    ay = $signed(p.ay);
    bx = $signed(p.bx);
    by = $signed(p.by);
    cx = $signed(p.cx);
    cy = $signed(p.cy);
    dx = $signed(p.dx);
    dy = $signed(p.dy);
    s1 = side_of_line(cross_term(cx, cy, dx, dy, ax, ay), tol);
    s2 = side_of_line(cross_term(cx, cy, dx, dy, bx, by), tol);
    s3 = side_of_line(cross_term(ax, ay, bx, by, cx, cy), tol);
    s4 = side_of_line(cross_term(ax, ay, bx, by, dx, dy), tol);
    // proper crossing: each segment straddles the other's line
    if (s1 * s2 == -1 && s3 * s4 == -1) return 1'b1;
    // collinear endpoint lying on the other segment
    return (s1 == 0 && in_box(cx, cy, dx, dy, ax, ay)) ||
           (s2 == 0 && in_box(cx, cy, dx, dy, bx, by)) ||
           (s3 == 0 && in_box(ax, ay, bx, by, cx, cy)) ||
           (s4 == 0 && in_box(ax, ay, bx, by, dx, dy));
  endfunction

  // ---------------------------------------------------------------------------
  // idling, sender and configuration
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t pair_row(input verdict_t want,
                                         input int ax, ay, bx, by, cx, cy, dx, dy);
    stim_row_t r;
    r.want = want;
    r.pair.ax = ax;
    r.pair.ay = ay;
    r.pair.bx = bx;
    r.pair.by = by;
    r.pair.cx = cx;
    r.pair.cy = cy;
    r.pair.dx = dx;
    r.pair.dy = dy;
    return r;
  endfunction

  // offer one pair, record its verdict on the transfer, then maybe idle;
  // with no gap tvalid stays high and the next call overwrites tdata in the
  // same step
  task automatic offer_pair(input seg_pair_t pair, input logic hit);
    int gap;
    in_tdata  <= pair;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_hits.push_back(hit);
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every outstanding verdict has been returned
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register writes only with the pipeline empty
  task automatic set_tolerance(input logic [TOL_WIDTH-1:0] value);
    wait_all_results();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we        <= 1'b0;
    tolerance_now = value;
  endtask

  // random pairs, weighted towards the shapes where the decision is delicate:
  // collinear runs, near-collinear nudges, degenerate points, shared endpoints
  task automatic run_random_phase(input int count, input bit hold_mid);
    logic [IN_TDATA_WIDTH-1:0] bits;
    coord_t v [NUM_COORDS];
    int kind, scale, ox, oy, ux, uy, k, j, src, dst;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 4) == 0);
      // receiver stalls for a long stretch while the sender keeps offering
      if (hold_mid && n >= count / 3 && n < count / 3 + 80) steady = 1'b1;
      if (hold_mid && n == count / 3) hold_asks++;

      kind  = $urandom_range(0, 99);
      scale = $urandom_range(0, 1) ? int'(ONE) : 1;
      for (int i = 0; i < NUM_COORDS; i++) v[i] = $urandom();

      if (kind < 15) begin
        // full-range noise, every bit of every field toggles
      end else if (kind < 35) begin
        // small grid, many touches and crossings
        for (int i = 0; i < NUM_COORDS; i++) v[i] = (int'($urandom_range(0, 8)) - 4) * scale;
      end else if (kind < 65) begin
        // four points on one line, some nudged slightly off it
        ox = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        oy = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        ux = (int'($urandom_range(0, 6)) - 3) * scale;
        uy = (int'($urandom_range(0, 6)) - 3) * scale;
        for (int i = 0; i < NUM_COORDS; i += 2) begin
          k = int'($urandom_range(0, 8)) - 4;
          v[i]     = ox + k * ux;
          v[i + 1] = oy + k * uy;
        end
        if (kind >= 55) begin
          j = $urandom_range(0, NUM_COORDS - 1);
          v[j] = v[j] + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 3));
        end
      end else if (kind < 75) begin
        // degenerate segments: one, the other or both collapse to a point
        for (int i = 0; i < NUM_COORDS; i++) v[i] = (int'($urandom_range(0, 6)) - 3) * scale;
        k = $urandom_range(0, 2);
        if (k != 1) begin
          v[F_BX] = v[F_AX];
          v[F_BY] = v[F_AY];
        end
        if (k != 0) begin
          v[F_DX] = v[F_CX];
          v[F_DY] = v[F_CY];
        end
      end else if (kind < 87) begin
        // an endpoint of the second segment equals one of the first
        src = $urandom_range(0, 1) ? F_BX : F_AX;
        dst = $urandom_range(0, 1) ? F_DX : F_CX;
        v[dst]     = v[src];
        v[dst + 1] = v[src + 1];
      end else begin
        // field extremes and values next to zero
        for (int i = 0; i < NUM_COORDS; i++) begin
          case ($urandom_range(0, 7))
            0: v[i] = C_MIN;
            1: v[i] = C_MAX;
            2: v[i] = '0;
            3: v[i] = '1;
            4: v[i] = 32'd1;
            5: v[i] = ONE;
            6: v[i] = -ONE;
            default: v[i] = $urandom();
          endcase
        end
      end

      for (int i = 0; i < NUM_COORDS; i++) bits[i * FIELD_WIDTH +: FIELD_WIDTH] = v[i];
      offer_pair(seg_pair_t'(bits), segments_meet(seg_pair_t'(bits), tolerance_now));
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: checks every transfer and drives out_tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    logic want_hit;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          $error("result transfer with no pair outstanding: intersects=%0b",
                 out_tdata[OUT_HIT_BIT]);
          mismatch_count++;
        end else begin
          want_hit = expected_hits.pop_front();
          if (out_tdata[OUT_HIT_BIT] !== want_hit) begin
            $error("intersects: expected %0b, got %0b", want_hit, out_tdata[OUT_HIT_BIT]);
            mismatch_count++;
          end
          if (out_tdata[OUT_TDATA_WIDTH-1:OUT_HIT_BIT+1] !== '0) begin
            $error("out_tdata padding: expected 0, got %0h",
                   out_tdata[OUT_TDATA_WIDTH-1:OUT_HIT_BIT+1]);
            mismatch_count++;
          end
        end
      end

      // a fresh hold request restarts the long count
      if (hold_seen != hold_asks) begin
        hold_seen  = hold_asks;
        ready_wait = LONG_HOLD;
      end
      if (ready_wait > 0) begin
        out_tready <= 1'b0;
        ready_wait--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        ready_wait = idle_cycles() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed_rows[$];
    stim_row_t r;
    logic hit;

    // directed rows at the reset tolerance; coordinates in Q16.16 unless raw
    // proper crossings, positive and signed
    directed_rows.push_back(pair_row(WANT_HIT, 0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
    directed_rows.push_back(pair_row(WANT_HIT, -2*ONE, -2*ONE, 2*ONE, 2*ONE,
                                     -2*ONE, 2*ONE, 2*ONE, -2*ONE));
    // parallel and apart
    directed_rows.push_back(pair_row(WANT_MISS, 0, 0, 2*ONE, 0, 0, ONE, 2*ONE, ONE));
    // lines cross beyond the end of the first segment
    directed_rows.push_back(pair_row(WANT_MISS, 0, 0, ONE, ONE, 3*ONE, 0, 2*ONE, ONE));
    // collinear overlapping, collinear disjoint
    directed_rows.push_back(pair_row(WANT_HIT, 0, 0, 2*ONE, 0, ONE, 0, 3*ONE, 0));
    directed_rows.push_back(pair_row(WANT_MISS, 0, 0, ONE, 0, 2*ONE, 0, 3*ONE, 0));
    // t-junction, shared endpoint
    directed_rows.push_back(pair_row(WANT_HIT, 0, 0, 2*ONE, 0, ONE, 0, ONE, 2*ONE));
    directed_rows.push_back(pair_row(WANT_HIT, 0, 0, ONE, ONE, ONE, ONE, 2*ONE, 0));
    // degenerate first segment on and off the second
    directed_rows.push_back(pair_row(WANT_HIT, ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE));
    directed_rows.push_back(pair_row(WANT_MISS, ONE, 2*ONE, ONE, 2*ONE, 0, 0, 2*ONE, 2*ONE));
    // two points, equal, then distinct (the distinct pair in raw units)
    directed_rows.push_back(pair_row(WANT_HIT, 3*ONE, -ONE, 3*ONE, -ONE,
                                     3*ONE, -ONE, 3*ONE, -ONE));
    directed_rows.push_back(pair_row(WANT_MISS, -1, -1, -1, -1, 0, 0, 0, 0));
    // every field zero, at the minimum, at the maximum
    directed_rows.push_back(pair_row(WANT_HIT, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pair_row(WANT_HIT, C_MIN, C_MIN, C_MIN, C_MIN,
                                     C_MIN, C_MIN, C_MIN, C_MIN));
    directed_rows.push_back(pair_row(WANT_HIT, C_MAX, C_MAX, C_MAX, C_MAX,
                                     C_MAX, C_MAX, C_MAX, C_MAX));
    // full-range diagonals both ways round, full-range parallels, full-range plus
    directed_rows.push_back(pair_row(WANT_HIT, C_MIN, C_MIN, C_MAX, C_MAX,
                                     C_MIN, C_MAX, C_MAX, C_MIN));
    directed_rows.push_back(pair_row(WANT_HIT, C_MAX, C_MIN, C_MIN, C_MAX,
                                     C_MIN, C_MIN, C_MAX, C_MAX));
    directed_rows.push_back(pair_row(WANT_MISS, C_MIN, C_MIN, C_MAX, C_MIN,
                                     C_MIN, C_MAX, C_MAX, C_MAX));
    directed_rows.push_back(pair_row(WANT_HIT, C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX));
    // raw units: a product exactly at the tolerance, just past it, and the
    // negative side of the band
    directed_rows.push_back(pair_row(WANT_MODEL, 0, 0, 4, 0, 2, 1, 2, 5));
    directed_rows.push_back(pair_row(WANT_MODEL, 0, 0, 5, 0, 2, 1, 2, -3));
    directed_rows.push_back(pair_row(WANT_MODEL, 0, 0, 4, 0, 2, -1, 2, -5));
    directed_rows.push_back(pair_row(WANT_MODEL, 0, 0, 5, 0, 2, -1, 2, 3));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r   = directed_rows[i];
      hit = (r.want == WANT_MODEL) ? segments_meet(r.pair, tolerance_now)
                                   : (r.want == WANT_HIT);
      offer_pair(r.pair, hit);
    end

    // random phases across tolerance settings, extremes included
    run_random_phase(300, 1'b1);
    set_tolerance('0);
    run_random_phase(200, 1'b0);
    set_tolerance('1);
    run_random_phase(150, 1'b0);
    set_tolerance($urandom_range(1, 64));
    run_random_phase(150, 1'b0);
    set_tolerance($urandom());
    run_random_phase(150, 1'b0);
    set_tolerance(TOL_RESET);
    run_random_phase(200, 1'b0);

    // drain, then leave room for anything the block should not send
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
